FILE: sv/rtm_pkg.sv
`timescale 1ns / 1ps

package rtm_pkg;

	// Largest RAM index plus one
	localparam int RAM_BYTES = 31;
	localparam logic [5:0] RAM_LIMIT = 6'(RAM_BYTES);

	// Command and frame constants
	localparam logic [7:0]  CMD_CLOCK_BASE = 8'h80;
	localparam logic [7:0]  CMD_RAM_BASE   = 8'hC0;
	localparam logic [7:0]  CMD_READ_BIT   = 8'h01;
	localparam logic [15:0] UNLOCK_WORD    = 16'h008E;
	localparam logic [15:0] RELOCK_WORD    = 16'h808E;
	localparam logic [4:0]  CLOCK_LAST     = 5'd6;
	localparam logic [7:0]  SECONDS_MASK   = 8'h7F;
	localparam logic [4:0]  FRAME_BITS     = 5'd16;
	localparam logic [7:0]  CLOCK_MAX      = 8'd99;

	// Frame sequence, one-hot
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_UNLOCK = 4'b0010,
		PH_ACCESS = 4'b0100,
		PH_RELOCK = 4'b1000
	} phase_t;

	// One tick item
	typedef struct packed {
		logic       start_req;
		logic       is_write;
		logic       target_ram;
		logic [4:0] address;
		logic [7:0] write_data;
		logic       io_sample;
	} rtm_in_t;

	// One tick result
	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_out;
		logic       data_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       address_error;
	} rtm_out_t;

	// Saturate to 99 and split into two BCD digits (divide by ten via reciprocal)
	function automatic logic [7:0] bin_to_bcd(input logic [7:0] d);
		logic [6:0]  sat;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		sat  = (d > CLOCK_MAX) ? CLOCK_MAX[6:0] : d[6:0];
		prod = 15'(sat) * 15'd205;
		tens = prod[14:11];
		ones = sat - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
		return {tens, ones[3:0]};
	endfunction

	// BCD digits back to binary, invalid digits taken as they stand
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		return 8'(b[3:0]) + 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0});
	endfunction

	// Command byte plus data byte of the access frame
	function automatic logic [15:0] access_word(input logic wr, input logic ram,
			input logic [4:0] addr, input logic [7:0] data, input logic bcd);
		logic [7:0] cmd;
		logic [7:0] d;
		cmd = (ram ? CMD_RAM_BASE : CMD_CLOCK_BASE) + {2'b00, addr, 1'b0};
		d   = data;
		if (!ram) begin
			d = (data > CLOCK_MAX) ? CLOCK_MAX : data;
			if (bcd) begin
				d = bin_to_bcd(data);
			end
		end
		return wr ? {d, cmd} : {8'h00, cmd | CMD_READ_BIT};
	endfunction

endpackage

FILE: sv/three_wire_rtc_master.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_stall | req_item  (rtm_in_t, one tick)
// rsp      | out       | rsp_valid / rsp_stall | rsp_item  (rtm_out_t, one per tick)
// cfg      | in        | cfg_we                | cfg_wdata (clock_bcd_enable)
//
// One item per clock while the result is not stalled; each item passes an input
// register, the tick logic of rtm_engine and the result register, which takes
// the result when the item advances out of the input register.
// A stalled result holds the input register, which then stalls req.
// Reset clears the link state and valids; clock_bcd_enable resets to 1.

module three_wire_rtc_master (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              req_valid,
	output logic              req_stall,
	input  rtm_pkg::rtm_in_t  req_item,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rtm_pkg::rtm_out_t rsp_item
);
	import rtm_pkg::*;

	logic     bcd_en_q;
	logic     valid_s1;
	rtm_in_t  item_s1;
	logic     rsp_valid_q;
	rtm_out_t rsp_item_q;
	rtm_out_t tick_res;
	logic     adv;
	logic     req_take;

	// Advance when the result register is free or being emptied
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_en_q <= 1'b1;
		end else if (cfg_we) begin
			bcd_en_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= req_item;
		end
	end

	rtm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.bcd_en (bcd_en_q),
		.item   (item_s1),
		.res    (tick_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_item_q <= tick_res;
		end
	end

endmodule

FILE: sv/rtm_engine.sv
`timescale 1ns / 1ps

module rtm_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             bcd_en,
	input  rtm_pkg::rtm_in_t item,
	output rtm_pkg::rtm_out_t res
);
	import rtm_pkg::*;

	phase_t      phase_q;
	logic [4:0]  bit_pos_q;
	logic        half_q;
	logic [15:0] shift_q;
	logic [7:0]  rx_byte_q;
	logic        rq_wr_q;
	logic        rq_ram_q;
	logic [4:0]  rq_addr_q;
	logic [7:0]  rq_data_q;
	logic [7:0]  result_q;

	phase_t      phase_d;
	logic [4:0]  bit_pos_d;
	logic        half_d;
	logic [15:0] shift_d;
	logic [7:0]  rx_byte_d;
	logic        rq_wr_d;
	logic        rq_ram_d;
	logic [4:0]  rq_addr_d;
	logic [7:0]  rq_data_d;
	logic [7:0]  result_d;
	logic        addr_ok;

	// Range check of the incoming request
	assign addr_ok = item.target_ram ? ({1'b0, item.address} < RAM_LIMIT)
	                                 : (item.address <= CLOCK_LAST);

	// One tick of the serial link
	always_comb begin
		logic       rx;
		logic [7:0] rd;
		phase_d   = phase_q;
		bit_pos_d = bit_pos_q;
		half_d    = half_q;
		shift_d   = shift_q;
		rx_byte_d = rx_byte_q;
		rq_wr_d   = rq_wr_q;
		rq_ram_d  = rq_ram_q;
		rq_addr_d = rq_addr_q;
		rq_data_d = rq_data_q;
		result_d  = result_q;
		rx        = 1'b0;
		rd        = rx_byte_q;
		res               = '0;
		res.data_drive    = 1'b1;

		// Latch a new request when idle
		if (phase_q == PH_IDLE && item.start_req) begin
			rq_wr_d   = item.is_write;
			rq_ram_d  = item.target_ram;
			rq_addr_d = item.address;
			rq_data_d = item.write_data;
			if (!addr_ok) begin
				res.done_res      = 1'b1;
				res.address_error = 1'b1;
				result_d          = 8'h00;
			end else begin
				phase_d   = item.is_write ? PH_UNLOCK : PH_ACCESS;
				bit_pos_d = 5'd0;
				half_d    = 1'b0;
				rx_byte_d = 8'h00;
				shift_d   = item.is_write ? UNLOCK_WORD
				          : access_word(item.is_write, item.target_ram, item.address,
				                        item.write_data, bcd_en);
			end
		end

		if (phase_d != PH_IDLE) begin
			if (bit_pos_d < FRAME_BITS) begin
				// Drive or receive one half bit
				rx = (phase_d == PH_ACCESS) && !rq_wr_d && bit_pos_d[3];
				res.chip_enable  = 1'b1;
				res.busy_res     = 1'b1;
				res.serial_clock = half_d;
				if (rx) begin
					res.data_drive = 1'b0;
					if (!half_d) begin
						rx_byte_d = {item.io_sample, rx_byte_d[7:1]};
					end
				end else begin
					res.data_out = shift_d[0];
				end
				if (!half_d) begin
					half_d = 1'b1;
				end else begin
					half_d    = 1'b0;
					shift_d   = {1'b0, shift_d[15:1]};
					bit_pos_d = bit_pos_d + 5'd1;
				end
			end else begin
				// Gap tick: chain the next frame or finish
				bit_pos_d = 5'd0;
				half_d    = 1'b0;
				if (phase_d == PH_UNLOCK) begin
					phase_d      = PH_ACCESS;
					shift_d      = access_word(rq_wr_d, rq_ram_d, rq_addr_d, rq_data_d, bcd_en);
					res.busy_res = 1'b1;
				end else if (phase_d == PH_ACCESS && rq_wr_d) begin
					phase_d      = PH_RELOCK;
					shift_d      = RELOCK_WORD;
					res.busy_res = 1'b1;
				end else begin
					rd = rx_byte_d;
					if (!rq_ram_d) begin
						if (rq_addr_d == 5'd0) begin
							rd = rd & SECONDS_MASK;
						end
						if (bcd_en) begin
							rd = bcd_to_bin(rd);
						end
					end
					result_d     = (phase_d == PH_ACCESS) ? rd : 8'h00;
					phase_d      = PH_IDLE;
					res.done_res = 1'b1;
				end
			end
		end
		res.read_data = result_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_pos_q <= 5'd0;
			half_q    <= 1'b0;
			shift_q   <= 16'h0000;
			rx_byte_q <= 8'h00;
			rq_wr_q   <= 1'b0;
			rq_ram_q  <= 1'b0;
			rq_addr_q <= 5'd0;
			rq_data_q <= 8'h00;
			result_q  <= 8'h00;
		end else if (adv) begin
			phase_q   <= phase_d;
			bit_pos_q <= bit_pos_d;
			half_q    <= half_d;
			shift_q   <= shift_d;
			rx_byte_q <= rx_byte_d;
			rq_wr_q   <= rq_wr_d;
			rq_ram_q  <= rq_ram_d;
			rq_addr_q <= rq_addr_d;
			rq_data_q <= rq_data_d;
			result_q  <= result_d;
		end
	end

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.done_res |-> !res.busy_res)
		else $error("done and busy together");
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.address_error |-> res.done_res && res.read_data == 8'h00)
		else $error("address error without done");
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= FRAME_BITS)
		else $error("bit position out of range");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_pos_q == 5'd0 && !half_q)
		else $error("idle with frame position set");
`endif

endmodule
